[rtl/psm_pkg.sv]
package psm_pkg;

	// Sizing of the block.
	localparam int PARTITIONS  = 16;
	localparam int BINS        = 257;
	localparam int SAMPLE_BITS = 16;

	// Fixed widths of the word fields.
	localparam int IN_W   = 16;
	localparam int BIN_W  = 9;
	localparam int PIDX_W = 4;
	localparam int ACC_W  = 40;

	// Derived sizes.
	localparam int DEPTH  = PARTITIONS * BINS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PART_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int TERM_W = PROD_W + 1;

	// Request type codes.
	localparam logic REQ_LOAD     = 1'b0;
	localparam logic REQ_SPECTRUM = 1'b1;

	typedef struct packed {
		logic                    req_type;
		logic [PIDX_W-1:0]       partition_index;
		logic [BIN_W-1:0]        bin_index;
		logic signed [IN_W-1:0]  value_re;
		logic signed [IN_W-1:0]  value_im;
		logic                    frame_last;
	} req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sum_re;
		logic signed [ACC_W-1:0] sum_im;
		logic [BIN_W-1:0]        out_bin;
		logic                    out_last;
	} rsp_t;

	// One complex sample as held in the stores.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] re;
		logic signed [SAMPLE_BITS-1:0] im;
	} cplx_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;
		logic issue;
	} cmac_ctl_t;

	typedef struct packed {
		logic busy;
	} cmac_stat_t;

	// Store address of one (row, bin) entry.
	function automatic logic [ADDR_W-1:0] row_addr(input logic [PART_W-1:0] row,
		input logic [BIN_W-1:0] bin);
		row_addr = ADDR_W'(row) * ADDR_W'(BINS) + ADDR_W'(bin);
	endfunction

	// Low SAMPLE_BITS of an input field, read as a signed sample.
	function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic [IN_W-1:0] raw);
		to_sample = SAMPLE_BITS'(raw);
	endfunction

endpackage

[rtl/psm_store.sv]
module psm_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [psm_pkg::ADDR_W-1:0]    waddr,
	input  psm_pkg::cplx_t                wdata,
	input  logic                          ren,
	input  logic [psm_pkg::ADDR_W-1:0]    raddr,
	output psm_pkg::cplx_t                rdata
);

	psm_pkg::cplx_t mem [psm_pkg::DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/psm_cmac.sv]
module psm_cmac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psm_pkg::cmac_ctl_t                  ctl,
	input  psm_pkg::cplx_t                      dl,
	input  psm_pkg::cplx_t                      cf,
	output psm_pkg::cmac_stat_t                 stat,
	output logic signed [psm_pkg::ACC_W-1:0]    acc_re,
	output logic signed [psm_pkg::ACC_W-1:0]    acc_im
);

	logic                                  valid_s1;
	logic                                  valid_s2;
	logic signed [psm_pkg::PROD_W-1:0]     p_rr;
	logic signed [psm_pkg::PROD_W-1:0]     p_ii;
	logic signed [psm_pkg::PROD_W-1:0]     p_ri;
	logic signed [psm_pkg::PROD_W-1:0]     p_ir;
	logic signed [psm_pkg::TERM_W-1:0]     term_re_s2;
	logic signed [psm_pkg::TERM_W-1:0]     term_im_s2;
	logic signed [psm_pkg::ACC_W-1:0]      acc_re_q;
	logic signed [psm_pkg::ACC_W-1:0]      acc_im_q;

	// Operand words arrive from the stores in the cycle after the read is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	// The four partial products of one complex multiplication.
	always_comb begin
		p_rr = dl.re * cf.re;
		p_ii = dl.im * cf.im;
		p_ri = dl.re * cf.im;
		p_ir = dl.im * cf.re;
	end

	// Registered complex product.
	always_ff @(posedge clk) begin
		term_re_s2 <= psm_pkg::TERM_W'(p_rr) - psm_pkg::TERM_W'(p_ii);
		term_im_s2 <= psm_pkg::TERM_W'(p_ri) + psm_pkg::TERM_W'(p_ir);
	end

	// Accumulator, cleared at the start of each bin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (ctl.clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (valid_s2) begin
			acc_re_q <= acc_re_q + psm_pkg::ACC_W'(term_re_s2);
			acc_im_q <= acc_im_q + psm_pkg::ACC_W'(term_im_s2);
		end
	end

	assign stat.busy = valid_s1 | valid_s2;
	assign acc_re    = acc_re_q;
	assign acc_im    = acc_im_q;

endmodule

[rtl/partitioned_spectrum_mac_unit.sv]
// Frequency-domain core of a uniformly partitioned convolver. A load word
// (req_type 0) stores one complex coefficient per partition and bin and gives
// no result. A spectrum word (req_type 1) writes its bin into the frequency
// delay line at the head row, then one shared complex multiply-accumulate unit
// walks all PARTITIONS rows, one per cycle, and the complex sum is returned as
// one result word; the next word is accepted only after the sum is formed, as
// each store has a single read port feeding the one multiply-accumulate unit
// and its pipeline must drain first. A spectrum word whose bin is out of range
// gives a zero sum. The head row advances on a spectrum word with frame_last
// set. Loads with an out-of-range partition or bin are dropped. After reset
// both stores are swept to zero over all PARTITIONS * BINS entries while
// req_ready stays low. A finished result waits in an output register, so the
// next word may be accepted while the result has not yet been taken; a
// further result waits in its last step until then.
module partitioned_spectrum_mac_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  psm_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output psm_pkg::rsp_t   rsp
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_APPLY  = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]                      state_q;
	logic [psm_pkg::ADDR_W-1:0]      clr_q;
	logic [psm_pkg::PART_W-1:0]      r_q;
	logic [psm_pkg::PART_W-1:0]      head_q;
	psm_pkg::req_t                   item_q;
	psm_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	logic                            is_load;
	logic                            bin_ok;
	logic                            part_ok;
	logic [psm_pkg::PART_W:0]        age_diff;
	logic [psm_pkg::PART_W-1:0]      age;
	psm_pkg::cplx_t                  sample;
	logic                            dl_we;
	logic                            cf_we;
	logic [psm_pkg::ADDR_W-1:0]      dl_waddr;
	logic [psm_pkg::ADDR_W-1:0]      cf_waddr;
	psm_pkg::cplx_t                  st_wdata;
	logic [psm_pkg::ADDR_W-1:0]      dl_raddr;
	logic [psm_pkg::ADDR_W-1:0]      cf_raddr;
	psm_pkg::cplx_t                  dl_rdata;
	psm_pkg::cplx_t                  cf_rdata;
	psm_pkg::cmac_ctl_t              cmac_ctl;
	psm_pkg::cmac_stat_t             cmac_stat;
	logic signed [psm_pkg::ACC_W-1:0] acc_re;
	logic signed [psm_pkg::ACC_W-1:0] acc_im;
	logic                            rsp_free;

	// Decode of the held word.
	assign is_load  = (item_q.req_type == psm_pkg::REQ_LOAD);
	assign bin_ok   = int'(item_q.bin_index) < psm_pkg::BINS;
	assign part_ok  = int'(item_q.partition_index) < psm_pkg::PARTITIONS;
	assign sample.re = psm_pkg::to_sample(item_q.value_re);
	assign sample.im = psm_pkg::to_sample(item_q.value_im);

	// Age of row r: the head row minus r, modulo the number of partitions.
	always_comb begin
		age_diff = {1'b0, head_q} - {1'b0, r_q};
		if (age_diff[psm_pkg::PART_W]) begin
			age = psm_pkg::PART_W'(age_diff + (psm_pkg::PART_W + 1)'(psm_pkg::PARTITIONS));
		end else begin
			age = age_diff[psm_pkg::PART_W-1:0];
		end
	end

	// Write ports: clearing sweep after reset, otherwise the held word.
	always_comb begin
		dl_we    = 1'b0;
		cf_we    = 1'b0;
		dl_waddr = psm_pkg::row_addr(head_q, item_q.bin_index);
		cf_waddr = psm_pkg::row_addr(psm_pkg::PART_W'(item_q.partition_index),
			item_q.bin_index);
		st_wdata = sample;
		if (state_q == ST_CLEAR) begin
			dl_we    = 1'b1;
			cf_we    = 1'b1;
			dl_waddr = clr_q;
			cf_waddr = clr_q;
			st_wdata = '0;
		end else if (state_q == ST_APPLY) begin
			dl_we = !is_load && bin_ok;
			cf_we = is_load && bin_ok && part_ok;
		end
	end

	// Read addresses for row r of the delay line and partition age of the filter.
	assign dl_raddr       = psm_pkg::row_addr(r_q, item_q.bin_index);
	assign cf_raddr       = psm_pkg::row_addr(age, item_q.bin_index);
	assign cmac_ctl.issue = (state_q == ST_RUN);
	assign cmac_ctl.clear = (state_q == ST_APPLY);

	psm_store u_dl_store (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (st_wdata),
		.ren   (cmac_ctl.issue),
		.raddr (dl_raddr),
		.rdata (dl_rdata)
	);

	psm_store u_cf_store (
		.clk   (clk),
		.we    (cf_we),
		.waddr (cf_waddr),
		.wdata (st_wdata),
		.ren   (cmac_ctl.issue),
		.raddr (cf_raddr),
		.rdata (cf_rdata)
	);

	psm_cmac u_cmac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cmac_ctl),
		.dl     (dl_rdata),
		.cf     (cf_rdata),
		.stat   (cmac_stat),
		.acc_re (acc_re),
		.acc_im (acc_im)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			r_q     <= '0;
			head_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == psm_pkg::ADDR_W'(psm_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					r_q <= '0;
					if (is_load) begin
						state_q <= ST_IDLE;
					end else if (bin_ok) begin
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_RUN: begin
					r_q <= r_q + 1'b1;
					if (r_q == psm_pkg::PART_W'(psm_pkg::PARTITIONS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!cmac_stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
						if (item_q.frame_last) begin
							if (head_q == psm_pkg::PART_W'(psm_pkg::PARTITIONS - 1)) begin
								head_q <= '0;
							end else begin
								head_q <= head_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input word register.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && rsp_free) begin
			rsp_q.sum_re   <= acc_re;
			rsp_q.sum_im   <= acc_im;
			rsp_q.out_bin  <= item_q.bin_index;
			rsp_q.out_last <= item_q.frame_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A new result word is only ever loaded from the finishing step.
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result word appeared outside the finishing step");

	// The multiply-accumulate pipeline is empty whenever a word may be accepted.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !cmac_stat.busy)
		else $error("multiply-accumulate pipeline busy while idle");

	// The head row stays inside the delay line.
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(head_q) < psm_pkg::PARTITIONS)
		else $error("head row out of range");

	// A finished result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("pending result word lost");

endmodule

[dv/partitioned_spectrum_mac_unit_test.sv]
module partitioned_spectrum_mac_unit_test;

	// Cycles with no word moving on either side before the run is abandoned.
	// The store sweep after reset alone covers all PARTITIONS * BINS entries.
	localparam int QUIET_LIMIT = 4 * psm_pkg::DEPTH + 4000;
	localparam int SETTLE_CYCLES = psm_pkg::PARTITIONS + 12;

	// Field values at the edges of the stores.
	localparam logic [psm_pkg::PIDX_W-1:0] TOP_PART =
		psm_pkg::PIDX_W'(psm_pkg::PARTITIONS - 1);
	localparam logic [psm_pkg::BIN_W-1:0] TOP_BIN = psm_pkg::BIN_W'(psm_pkg::BINS - 1);
	localparam logic [psm_pkg::BIN_W-1:0] PAST_BIN = psm_pkg::BIN_W'(psm_pkg::BINS);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	psm_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	psm_pkg::rsp_t rsp;

	// Own copy of the block state, updated as words are accepted.
	psm_pkg::cplx_t coef_tab [psm_pkg::DEPTH];
	psm_pkg::cplx_t line_tab [psm_pkg::DEPTH];
	int head_row;

	// Sums still owed by the block, oldest first.
	psm_pkg::rsp_t owed_sums [$];

	int mismatches = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	partitioned_spectrum_mac_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random except during the steady stretch.
	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(99) >= 16);
	end

	task automatic note_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
	endtask

	// Apply one accepted word to the local state and queue the sum it owes.
	task automatic apply_word(input psm_pkg::req_t w);
		int row;
		int age;
		int bin;
		longint ar, ai, br, bi;
		longint acc_re, acc_im;
		psm_pkg::cplx_t s;
		psm_pkg::rsp_t r;
		s.re = w.value_re[psm_pkg::SAMPLE_BITS-1:0];
		s.im = w.value_im[psm_pkg::SAMPLE_BITS-1:0];
		bin = int'(w.bin_index);
		acc_re = 0;
		acc_im = 0;
		if (w.req_type == psm_pkg::REQ_LOAD) begin
			// Loads outside the stores are dropped and owe nothing.
			if (int'(w.partition_index) < psm_pkg::PARTITIONS && bin < psm_pkg::BINS)
				coef_tab[int'(w.partition_index) * psm_pkg::BINS + bin] = s;
		end else begin
			if (bin < psm_pkg::BINS) begin
				line_tab[head_row * psm_pkg::BINS + bin] = s;
				for (row = 0; row < psm_pkg::PARTITIONS; row++) begin
					age = (head_row + psm_pkg::PARTITIONS - row) % psm_pkg::PARTITIONS;
					ar = $signed(line_tab[row * psm_pkg::BINS + bin].re);
					ai = $signed(line_tab[row * psm_pkg::BINS + bin].im);
					br = $signed(coef_tab[age * psm_pkg::BINS + bin].re);
					bi = $signed(coef_tab[age * psm_pkg::BINS + bin].im);
					acc_re += ar * br - ai * bi;
					acc_im += ar * bi + ai * br;
				end
			end
			// An out-of-range bin still closes the frame when flagged.
			if (w.frame_last)
				head_row = (head_row + 1) % psm_pkg::PARTITIONS;
			r.sum_re = acc_re[psm_pkg::ACC_W-1:0];
			r.sum_im = acc_im[psm_pkg::ACC_W-1:0];
			r.out_bin = w.bin_index;
			r.out_last = w.frame_last;
			owed_sums.push_back(r);
		end
	endtask

	// Send one word, idling at random first, and record it once accepted.
	task automatic send_word(input psm_pkg::req_t w);
		if (!steady) begin
			while ($urandom_range(99) < 16) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		apply_word(w);
	endtask

	// Hold the sender back until every owed sum has been returned.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (owed_sums.size() != 0);
	endtask

	function automatic psm_pkg::req_t make_word(input logic kind,
		input logic [psm_pkg::PIDX_W-1:0] part, input logic [psm_pkg::BIN_W-1:0] bin,
		input logic [psm_pkg::IN_W-1:0] re, input logic [psm_pkg::IN_W-1:0] im,
		input logic last);
		psm_pkg::req_t w;
		w.req_type = kind;
		w.partition_index = part;
		w.bin_index = bin;
		w.value_re = re;
		w.value_im = im;
		w.frame_last = last;
		return w;
	endfunction

	// Sample values lean towards the two extremes now and then.
	function automatic logic [psm_pkg::IN_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			default: return psm_pkg::IN_W'($urandom);
		endcase
	endfunction

	// Each result is compared with the oldest owed sum.
	always @(posedge clk) begin
		psm_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (owed_sums.size() == 0) begin
				note_mismatch("unexpected result, bin", rsp.out_bin, -1);
			end else begin
				want = owed_sums.pop_front();
				if (rsp.sum_re !== want.sum_re)
					note_mismatch("sum_re", rsp.sum_re, want.sum_re);
				if (rsp.sum_im !== want.sum_im)
					note_mismatch("sum_im", rsp.sum_im, want.sum_im);
				if (rsp.out_bin !== want.out_bin)
					note_mismatch("out_bin", rsp.out_bin, want.out_bin);
				if (rsp.out_last !== want.out_last)
					note_mismatch("out_last", rsp.out_last, want.out_last);
			end
		end
	end

	// Watchdog on cycles in which no word is accepted on either side.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Coefficient loads at the corners of the stores, and loads that fall outside.
	task automatic test_load_extremes();
		send_word(make_word(psm_pkg::REQ_LOAD, 4'd0, 9'd0, 16'h7fff, 16'h8000, 1'b0));
		send_word(make_word(psm_pkg::REQ_LOAD, TOP_PART, TOP_BIN, 16'h8000, 16'h8000, 1'b1));
		send_word(make_word(psm_pkg::REQ_LOAD, 4'd1, 9'd0, 16'h8000, 16'h7fff, 1'b0));
		send_word(make_word(psm_pkg::REQ_LOAD, 4'd3, PAST_BIN, 16'h1234, 16'h4321, 1'b0));
		send_word(make_word(psm_pkg::REQ_LOAD, TOP_PART, 9'h1ff, 16'hffff, 16'hffff, 1'b1));
	endtask

	// Spectrum words at the edge bins, including bins beyond the stores.
	task automatic test_spectrum_edges();
		send_word(make_word(psm_pkg::REQ_SPECTRUM, 4'hf, 9'd0, 16'h8000, 16'h8000, 1'b0));
		send_word(make_word(psm_pkg::REQ_SPECTRUM, 4'd0, TOP_BIN, 16'h7fff, 16'h8000, 1'b0));
		send_word(make_word(psm_pkg::REQ_SPECTRUM, 4'h5, PAST_BIN, 16'h7fff, 16'h7fff, 1'b1));
		send_word(make_word(psm_pkg::REQ_SPECTRUM, 4'ha, 9'h1ff, 16'h8000, 16'h0001, 1'b0));
		send_word(make_word(psm_pkg::REQ_SPECTRUM, 4'd0, 9'd0, 16'h7fff, 16'h7fff, 1'b1));
	endtask

	// Single-bin frames walk the head row round past its wrap.
	task automatic test_head_wrap();
		int k;
		for (k = 0; k < psm_pkg::PARTITIONS - 1; k++)
			send_word(make_word(psm_pkg::REQ_SPECTRUM, psm_pkg::PIDX_W'(k), 9'd0,
				pick_sample(), pick_sample(), 1'b1));
	endtask

	// Mostly frames over a narrow window of bins so that the delay line fills
	// and ages, with coefficient loads among them and some fully random words.
	task automatic test_random_traffic(input int words);
		int k;
		int roll;
		int base;
		base = 0;
		for (k = 0; k < words; k++) begin
			if (k % 64 == 0) begin
				roll = $urandom_range(3);
				base = (roll == 0) ? psm_pkg::BINS - 4 : $urandom_range(psm_pkg::BINS - 4);
			end
			steady = (k >= words / 3) && (k < words / 3 + 300);
			roll = $urandom_range(99);
			if (roll < 25)
				send_word(make_word(psm_pkg::REQ_LOAD,
					psm_pkg::PIDX_W'($urandom_range(psm_pkg::PARTITIONS - 1)),
					psm_pkg::BIN_W'(base + $urandom_range(3)), pick_sample(),
					pick_sample(), 1'($urandom_range(1))));
			else if (roll < 88)
				send_word(make_word(psm_pkg::REQ_SPECTRUM,
					psm_pkg::PIDX_W'($urandom_range(15)),
					psm_pkg::BIN_W'(base + $urandom_range(3)), pick_sample(),
					pick_sample(), $urandom_range(2) == 0));
			else
				send_word(make_word(1'($urandom_range(1)),
					psm_pkg::PIDX_W'($urandom_range(15)),
					psm_pkg::BIN_W'($urandom_range(511)), psm_pkg::IN_W'($urandom),
					psm_pkg::IN_W'($urandom), 1'($urandom_range(1))));
		end
		steady = 1'b0;
	endtask

	initial begin
		int k;
		for (k = 0; k < psm_pkg::DEPTH; k++) begin
			coef_tab[k] = '0;
			line_tab[k] = '0;
		end
		head_row = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_load_extremes();
		test_spectrum_edges();
		test_head_wrap();
		wait_drained();
		test_random_traffic(1925);

		// Let the last sums come home, then a short settling time.
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[partitioned_spectrum_mac_unit.f]
rtl/psm_pkg.sv
rtl/psm_store.sv
rtl/psm_cmac.sv
rtl/partitioned_spectrum_mac_unit.sv
dv/partitioned_spectrum_mac_unit_test.sv
